// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sprite motion checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite motion assertion failed");

// Next-cycle implication, disabled during reset.
`define SBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite motion assertion failed");

`endif

// ----- src/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbm_pkg
// Types, codes and per-axis motion helpers for the sprite motion step.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int CoordWidth = 16;
   localparam int SizeWidth  = 12;
   localparam int WideWidth  = 19;
   localparam int CsrIdxWidth = 3;

   // transaction codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_LOAD = 2'd1;
   localparam logic [1:0] REQ_KILL = 2'd2;

   // edge actions
   localparam logic [1:0] MODE_WRAP   = 2'd0;
   localparam logic [1:0] MODE_BOUNCE = 2'd1;
   localparam logic [1:0] MODE_DIE    = 2'd2;
   localparam logic [1:0] MODE_STOP   = 2'd3;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_BOUND_LEFT    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BOUND_TOP     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_BOUND_RIGHT   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_BOUND_BOTTOM  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_SPRITE_WIDTH  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_SPRITE_HEIGHT = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_BOUNDS_MODE   = 3'd6;

   typedef struct packed {
      logic signed [CoordWidth-1:0] bound_left;
      logic signed [CoordWidth-1:0] bound_top;
      logic signed [CoordWidth-1:0] bound_right;
      logic signed [CoordWidth-1:0] bound_bottom;
      logic        [SizeWidth-1:0]  sprite_width;
      logic        [SizeWidth-1:0]  sprite_height;
      logic        [1:0]            bounds_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] vx;
      logic signed [CoordWidth-1:0] vy;
      logic                         kill;
   } result_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos;
      logic                         flip;
      logic                         hit;
      logic                         leave;
   } axis_res_type;

   function automatic logic signed [CoordWidth-1:0] sat16(input logic signed [WideWidth-1:0] v);
      logic signed [CoordWidth-1:0] r;
      if (v > 19'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[CoordWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] neg_sat16(
      input logic signed [CoordWidth-1:0] v);
      logic signed [CoordWidth-1:0] r;
      if (v == 16'sh8000) begin
         r = 16'sh7fff;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // One axis of a tick: move, then apply the edge action of the given mode.
   function automatic axis_res_type axis_step(
      input logic signed [CoordWidth-1:0] pos,
      input logic signed [CoordWidth-1:0] vel,
      input logic signed [CoordWidth-1:0] lo,
      input logic signed [CoordWidth-1:0] hi,
      input logic        [SizeWidth-1:0]  size,
      input logic        [1:0]            mode);
      logic signed [WideWidth-1:0] n;
      logic signed [WideWidth-1:0] s;
      logic signed [WideWidth-1:0] lo_e;
      logic signed [WideWidth-1:0] hi_e;
      logic signed [WideWidth-1:0] hi_w;
      logic signed [WideWidth-1:0] c;
      logic signed [WideWidth-1:0] p;
      axis_res_type r;
      n    = WideWidth'(pos) + WideWidth'(vel);
      s    = signed'({{(WideWidth-SizeWidth){1'b0}}, size});
      lo_e = WideWidth'(lo);
      hi_e = WideWidth'(hi);
      hi_w = hi_e - s;
      c    = (n < hi_w) ? n : hi_w;
      p    = n;
      r    = '0;
      case (mode)
         MODE_WRAP: begin
            if (n + s < lo_e) begin
               p = hi_e;
            end else if (n > hi_e) begin
               p = lo_e - s;
            end
         end
         MODE_BOUNCE: begin
            if (n < lo_e) begin
               p = lo_e;
               r.flip = 1'b1;
            end else if (n + s > hi_e) begin
               p = hi_w;
               r.flip = 1'b1;
            end
         end
         MODE_DIE: begin
            r.leave = (n + s < lo_e) || (n > hi_e);
         end
         default: begin
            // stop: clamp into the rectangle, low edge wins
            if ((n < lo_e) || (n > hi_w)) begin
               r.hit = 1'b1;
               p = (c > lo_e) ? c : lo_e;
            end
         end
      endcase
      r.pos = sat16(p);
      return r;
   endfunction

endpackage

// ----- src/sprite_bounds_motion_step.sv -----
// ----------------------------------------------------------------------------
// sprite_bounds_motion_step
// Moves one sprite per tick transaction inside a configurable rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction (tick, load or mark dying) with valid/stall;
//   rsp_* returns exactly one result per transaction: the sprite state after
//   it and a kill bit. csr_* writes the bounds, sprite size and edge action;
//   write it only while no transaction is in flight.
//   A transaction is held in the input register, then in the result register,
//   which drives rsp_*. Throughput: one transaction per cycle while rsp_stall
//   stays low; the input register feeds the update logic, which writes the
//   sprite state and the result register at the same edge, so the next
//   transaction sees the new state.
//   rsp_stall holds the result register; the input register still takes one
//   more transaction, then req_stall rises until the result is taken.
//   Reset (synchronous) empties both registers, clears the sprite state and
//   loads the default rectangle 0..639 x 0..479, 16x16 sprite, stop mode.
// ----------------------------------------------------------------------------
module sprite_bounds_motion_step
   import sbm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic signed [CoordWidth-1:0]  req_load_x,
   input  logic signed [CoordWidth-1:0]  req_load_y,
   input  logic signed [CoordWidth-1:0]  req_load_vx,
   input  logic signed [CoordWidth-1:0]  req_load_vy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [CoordWidth-1:0]  rsp_out_x,
   output logic signed [CoordWidth-1:0]  rsp_out_y,
   output logic signed [CoordWidth-1:0]  rsp_out_vx,
   output logic signed [CoordWidth-1:0]  rsp_out_vy,
   output logic                          rsp_kill,
   input  logic                          csr_wr_en,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CoordWidth-1:0]         csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic                         in_valid_ff, in_valid_in;
   logic [1:0]                   in_type_ff;
   logic signed [CoordWidth-1:0] in_x_ff, in_y_ff, in_vx_ff, in_vy_ff;
   logic                         out_valid_ff, out_valid_in;
   result_type                   out_ff;
   logic                         advance;
   logic                         accept;

   // result register free or being emptied this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_x_ff    <= req_load_x;
         in_y_ff    <= req_load_y;
         in_vx_ff   <= req_load_vx;
         in_vy_ff   <= req_load_vy;
      end
      if (advance && in_valid_ff) begin
         out_ff <= result;
      end
   end

   sbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance && in_valid_ff),
      .req_type (in_type_ff),
      .load_x   (in_x_ff),
      .load_y   (in_y_ff),
      .load_vx  (in_vx_ff),
      .load_vy  (in_vy_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_out_x  = out_ff.x;
   assign rsp_out_y  = out_ff.y;
   assign rsp_out_vx = out_ff.vx;
   assign rsp_out_vy = out_ff.vy;
   assign rsp_kill   = out_ff.kill;

endmodule

// ----- src/sbm_csr.sv -----
// ----------------------------------------------------------------------------
// sbm_csr
// Configuration registers: bounds rectangle, sprite size and edge action.
// ----------------------------------------------------------------------------
module sbm_csr
   import sbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CoordWidth-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BOUND_LEFT:    cfg_in.bound_left    = csr_wdata;
            CSR_BOUND_TOP:     cfg_in.bound_top     = csr_wdata;
            CSR_BOUND_RIGHT:   cfg_in.bound_right   = csr_wdata;
            CSR_BOUND_BOTTOM:  cfg_in.bound_bottom  = csr_wdata;
            CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_wdata[SizeWidth-1:0];
            CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_wdata[SizeWidth-1:0];
            CSR_BOUNDS_MODE:   cfg_in.bounds_mode   = csr_wdata[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bound_left    <= 16'sd0;
         cfg_ff.bound_top     <= 16'sd0;
         cfg_ff.bound_right   <= 16'sd639;
         cfg_ff.bound_bottom  <= 16'sd479;
         cfg_ff.sprite_width  <= 12'd16;
         cfg_ff.sprite_height <= 12'd16;
         cfg_ff.bounds_mode   <= MODE_STOP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/sbm_core.sv -----
// ----------------------------------------------------------------------------
// sbm_core
// Sprite state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module sbm_core
   import sbm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [1:0]                   req_type,
   input  logic signed [CoordWidth-1:0] load_x,
   input  logic signed [CoordWidth-1:0] load_y,
   input  logic signed [CoordWidth-1:0] load_vx,
   input  logic signed [CoordWidth-1:0] load_vy,
   input  cfg_type                      cfg,
   output result_type                   result
);

   logic signed [CoordWidth-1:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic signed [CoordWidth-1:0] pos_x_in, pos_y_in, vel_x_in, vel_y_in;
   logic                         dying_ff, dying_in;
   logic                         kill;
   axis_res_type                 ax, ay;

   assign ax = axis_step(pos_x_ff, vel_x_ff, cfg.bound_left, cfg.bound_right,
                         cfg.sprite_width, cfg.bounds_mode);
   assign ay = axis_step(pos_y_ff, vel_y_ff, cfg.bound_top, cfg.bound_bottom,
                         cfg.sprite_height, cfg.bounds_mode);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      dying_in = dying_ff;
      kill     = 1'b0;
      unique case (req_type)
         REQ_LOAD: begin
            pos_x_in = load_x;
            pos_y_in = load_y;
            vel_x_in = load_vx;
            vel_y_in = load_vy;
            dying_in = 1'b0;
         end
         REQ_KILL: begin
            dying_in = 1'b1;
            kill     = 1'b1;
         end
         REQ_TICK: begin
            if (dying_ff) begin
               kill = 1'b1;
            end else if ((cfg.bounds_mode == MODE_DIE) && (ax.leave || ay.leave)) begin
               // left the rectangle: report, hold everything
               kill = 1'b1;
            end else begin
               pos_x_in = ax.pos;
               pos_y_in = ay.pos;
               if (ax.flip) vel_x_in = neg_sat16(vel_x_ff);
               if (ay.flip) vel_y_in = neg_sat16(vel_y_ff);
               if (ax.hit || ay.hit) begin
                  vel_x_in = '0;
                  vel_y_in = '0;
               end
            end
         end
         default: begin
            kill = dying_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         dying_ff <= 1'b0;
      end else if (step) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         dying_ff <= dying_in;
      end
   end

   assign result.x    = pos_x_in;
   assign result.y    = pos_y_in;
   assign result.vx   = vel_x_in;
   assign result.vy   = vel_y_in;
   assign result.kill = kill;

endmodule

// ----- src/sbm_checker.sv -----
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks for the sprite motion step, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbm_checker
   import sbm_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_type,
   input logic signed [CoordWidth-1:0]  req_load_x,
   input logic signed [CoordWidth-1:0]  req_load_y,
   input logic signed [CoordWidth-1:0]  req_load_vx,
   input logic signed [CoordWidth-1:0]  req_load_vy,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [CoordWidth-1:0]  rsp_out_x,
   input logic signed [CoordWidth-1:0]  rsp_out_y,
   input logic signed [CoordWidth-1:0]  rsp_out_vx,
   input logic signed [CoordWidth-1:0]  rsp_out_vy,
   input logic                          rsp_kill
);

   logic                    req_fire;
   logic                    kill_fire;
   logic                    load_fire;
   logic [2*CoordWidth:0]   rsp_snap;
   logic [4*CoordWidth-1:0] rsp_word;
   logic [4*CoordWidth-1:0] load_d1_in;
   logic [4*CoordWidth-1:0] load_d1_ff;
   logic [4*CoordWidth-1:0] load_d2_ff;
   logic                    load_echo;

   assign req_fire   = req_valid && !req_stall;
   assign kill_fire  = req_fire && (req_type == REQ_KILL);
   assign load_fire  = req_fire && (req_type == REQ_LOAD);
   assign rsp_snap   = {rsp_out_x, rsp_out_vy, rsp_kill};
   assign rsp_word   = {rsp_out_x, rsp_out_y, rsp_out_vx, rsp_out_vy};
   assign load_d1_in = {req_load_x, req_load_y, req_load_vx, req_load_vy};
   assign load_echo  = rsp_valid && !rsp_kill && (rsp_word == load_d2_ff);

   // keep the request payload, delayed through load_d1_ff and load_d2_ff
   always_ff @(posedge clock) begin
      load_d1_ff <= load_d1_in;
      load_d2_ff <= load_d1_ff;
   end

   // an empty result register never backs up the input side
   `SBM_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // a stalled result stays valid and holds its x, vy and kill fields
   `SBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_snap))

   // a kill transaction reports kill when the output drains
   `SBM_ASSERT_NEXT(a_kill_result, clock, reset, kill_fire ##1 !rsp_stall, rsp_valid && rsp_kill)

   // a load transaction returns its own values with kill clear
   `SBM_ASSERT_NEXT(a_load_result, clock, reset, load_fire ##1 !rsp_stall, load_echo)

endmodule

bind sprite_bounds_motion_step sbm_checker u_checker (.*);
